### rtl/htlp_pkg.sv
// Shared types, constants and helper functions for the linear-probing hash table.
// No dependencies; used by htlp_slot_store and hash_table_linear_probe_core.
package htlp_pkg;

    // Table geometry
    localparam int TABLE_SLOTS   = 128;
    localparam int MAX_KEY_BYTES = 8;
    localparam int SLOT_IDX_W    = $clog2(TABLE_SLOTS);

    // Field widths fixed by the stream format
    localparam int OP_W        = 2;
    localparam int KEY_W       = 64;
    localparam int LEN_W       = 4;
    localparam int SLOT_NUM_W  = 7;
    localparam int TABLE_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int KEY_BYTES   = KEY_W / 8;

    // Input beat layout (tdata): key_bytes, key_length, slot_number, asked_table
    localparam int IN_LEN_LSB    = KEY_W;
    localparam int IN_SLOT_LSB   = IN_LEN_LSB + LEN_W;
    localparam int IN_ASKED_LSB  = IN_SLOT_LSB + SLOT_NUM_W;
    localparam int IN_FIELDS_W   = IN_ASKED_LSB + TABLE_W;
    localparam int IN_DATA_W     = ((IN_FIELDS_W + 7) / 8) * 8;

    // Output beat layout (tdata): result_table, result_slot, result_key, result_length
    localparam int OUT_FIELDS_W  = TABLE_W + SLOT_NUM_W + KEY_W + LEN_W;
    localparam int OUT_DATA_W    = ((OUT_FIELDS_W + 7) / 8) * 8;

    // Home-slot arithmetic
    localparam int SUM_W     = $clog2(MAX_KEY_BYTES * 255 + 1);
    localparam int RED_W     = SUM_W + 1;
    localparam int RED_STEPS = SUM_W - SLOT_IDX_W + 1;
    localparam int RANGE_W   = ((SLOT_IDX_W > SLOT_NUM_W) ? SLOT_IDX_W : SLOT_NUM_W) + 1;

    // Operation codes
    localparam logic [OP_W-1:0] OP_PUT    = 2'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
    localparam logic [OP_W-1:0] OP_READ   = 2'd2;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND   = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_FULL        = 2'd2;
    localparam logic [STATUS_W-1:0] STAT_WRONG_TABLE = 2'd3;

    localparam logic [TABLE_W-1:0] TABLE_ID_RESET = 4'd1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_HASH,
        ST_CHECK,
        ST_OUT
    } state_t;

    // Request from the sequencer to the slot store
    typedef struct packed {
        logic                  rd_en;
        logic [SLOT_IDX_W-1:0] rd_addr;
        logic                  wr_en;
        logic [SLOT_IDX_W-1:0] wr_addr;
        logic [KEY_W-1:0]      wr_key;
        logic [LEN_W-1:0]      wr_len;
    } store_req_t;

    // Limit a length to the largest key
    function automatic logic [LEN_W-1:0] clamp_len(input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] lim;
        lim = LEN_W'(MAX_KEY_BYTES);
        return (len > lim) ? lim : len;
    endfunction

    // Zero the bytes at or beyond the length
    function automatic logic [KEY_W-1:0] mask_key(input logic [KEY_W-1:0] key,
                                                  input logic [LEN_W-1:0] len);
        logic [KEY_W-1:0] res;
        res = '0;
        for (int i = 0; i < KEY_BYTES; i++) begin
            if (i < int'(len)) begin
                res[8*i +: 8] = key[8*i +: 8];
            end
        end
        return res;
    endfunction

    // Sum of the key bytes (key already masked)
    function automatic logic [SUM_W-1:0] key_sum(input logic [KEY_W-1:0] key);
        logic [SUM_W-1:0] acc;
        acc = '0;
        for (int i = 0; i < MAX_KEY_BYTES; i++) begin
            acc = acc + SUM_W'(key[8*i +: 8]);
        end
        return acc;
    endfunction

    // Byte sum modulo the slot count by restoring compare-subtract steps
    function automatic logic [SLOT_IDX_W-1:0] home_slot(input logic [SUM_W-1:0] sum);
        logic [RED_W-1:0] val;
        logic [RED_W-1:0] dvs;
        val = RED_W'(sum);
        for (int k = RED_STEPS - 1; k >= 0; k--) begin
            dvs = RED_W'(TABLE_SLOTS) << k;
            if (val >= dvs) begin
                val = val - dvs;
            end
        end
        return SLOT_IDX_W'(val);
    endfunction

endpackage

### rtl/htlp_slot_store.sv
// Slot store: occupancy flags in flip-flops plus a synchronous key/length memory.
// Depends on htlp_pkg (geometry, store_req_t).
module htlp_slot_store
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  htlp_pkg::store_req_t              req,
    output logic                              rd_used,
    output logic [htlp_pkg::KEY_W-1:0]        rd_key,
    output logic [htlp_pkg::LEN_W-1:0]        rd_len
);

    logic [htlp_pkg::TABLE_SLOTS-1:0]                        used_reg;
    logic [htlp_pkg::KEY_W+htlp_pkg::LEN_W-1:0]              entry_mem [htlp_pkg::TABLE_SLOTS];
    logic [htlp_pkg::KEY_W+htlp_pkg::LEN_W-1:0]              rd_data_reg;
    logic                                                    rd_used_reg;

    // Occupancy flags clear at reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg <= '0;
        end
        else if (req.wr_en)
        begin
            used_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Entry memory, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            entry_mem[req.wr_addr] <= {req.wr_len, req.wr_key};
        end
        if (req.rd_en)
        begin
            rd_data_reg <= entry_mem[req.rd_addr];
            rd_used_reg <= used_reg[req.rd_addr];
        end
    end

    assign rd_used = rd_used_reg;
    assign rd_key  = rd_data_reg[htlp_pkg::KEY_W-1:0];
    assign rd_len  = rd_data_reg[htlp_pkg::KEY_W +: htlp_pkg::LEN_W];

endmodule

### rtl/hash_table_linear_probe_core.sv
// Linear-probing hash table: put, lookup and read-by-slot over a 128-slot store; depends on
// htlp_pkg and htlp_slot_store. Put and lookup walk from the home slot, P = slots probed
// (1..128), one probe per cycle on the single read port of the key memory. A request is
// taken only in idle: the next input beat is taken in the cycle after the result loads into
// the output register, and that load waits while the output stalls. Reset (rst_n, async
// low) empties all slots at once and sets table_id to 1.
module hash_table_linear_probe_core
(
    input  logic                               clk,
    input  logic                               rst_n,

    // Request stream
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    // tdata, from bit 0: key_bytes[63:0], key_length[3:0], slot_number[6:0],
    // asked_table[3:0], zero pad
    input  logic [htlp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // tuser: operation[1:0]
    input  logic [htlp_pkg::OP_W-1:0]          s_axis_tuser,

    // Result stream
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    // tdata, from bit 0: result_table[3:0], result_slot[6:0], result_key[63:0],
    // result_length[3:0], zero pad
    output logic [htlp_pkg::OUT_DATA_W-1:0]    m_axis_tdata,
    // tuser: status[1:0]
    output logic [htlp_pkg::STATUS_W-1:0]      m_axis_tuser,

    // table_id register write
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [htlp_pkg::TABLE_W-1:0]       cfg_data
);

    localparam logic [htlp_pkg::SLOT_IDX_W-1:0] LAST_SLOT =
        htlp_pkg::SLOT_IDX_W'(htlp_pkg::TABLE_SLOTS - 1);

    // ------------------------------------------------------------------
    // Input field unpack
    // ------------------------------------------------------------------
    logic [htlp_pkg::KEY_W-1:0]      in_key;
    logic [htlp_pkg::LEN_W-1:0]      in_len;
    logic [htlp_pkg::SLOT_NUM_W-1:0] in_slot;
    logic [htlp_pkg::TABLE_W-1:0]    in_asked;
    logic [htlp_pkg::LEN_W-1:0]      in_len_clamped;
    logic [htlp_pkg::KEY_W-1:0]      in_key_masked;

    assign in_key   = s_axis_tdata[htlp_pkg::KEY_W-1:0];
    assign in_len   = s_axis_tdata[htlp_pkg::IN_LEN_LSB +: htlp_pkg::LEN_W];
    assign in_slot  = s_axis_tdata[htlp_pkg::IN_SLOT_LSB +: htlp_pkg::SLOT_NUM_W];
    assign in_asked = s_axis_tdata[htlp_pkg::IN_ASKED_LSB +: htlp_pkg::TABLE_W];

    // Canonical key: clamp the length, drop stray bytes past it
    assign in_len_clamped = htlp_pkg::clamp_len(in_len);
    assign in_key_masked  = htlp_pkg::mask_key(in_key, in_len_clamped);

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    htlp_pkg::state_t                   state_reg, state_next;
    logic [htlp_pkg::TABLE_W-1:0]       table_id_reg;

    // Request held for the whole walk
    logic [htlp_pkg::OP_W-1:0]          op_reg, op_next;
    logic [htlp_pkg::KEY_W-1:0]         key_reg, key_next;
    logic [htlp_pkg::LEN_W-1:0]         len_reg, len_next;
    logic [htlp_pkg::SLOT_NUM_W-1:0]    slot_reg, slot_next;
    logic [htlp_pkg::TABLE_W-1:0]       asked_reg, asked_next;
    logic [htlp_pkg::SUM_W-1:0]         sum_reg, sum_next;

    // Probe walk
    logic [htlp_pkg::SLOT_IDX_W-1:0]    ptr_reg, ptr_next;
    logic [htlp_pkg::SLOT_IDX_W-1:0]    cnt_reg, cnt_next;

    // Finished result waiting for the output register
    logic [htlp_pkg::STATUS_W-1:0]      res_status_reg, res_status_next;
    logic [htlp_pkg::TABLE_W-1:0]       res_table_reg, res_table_next;
    logic [htlp_pkg::SLOT_NUM_W-1:0]    res_slot_reg, res_slot_next;
    logic [htlp_pkg::KEY_W-1:0]         res_key_reg, res_key_next;
    logic [htlp_pkg::LEN_W-1:0]         res_len_reg, res_len_next;

    // Output register
    logic                               out_valid_reg, out_valid_next;
    logic                               out_load;
    logic [htlp_pkg::STATUS_W-1:0]      out_status_reg;
    logic [htlp_pkg::TABLE_W-1:0]       out_table_reg;
    logic [htlp_pkg::SLOT_NUM_W-1:0]    out_slot_reg;
    logic [htlp_pkg::KEY_W-1:0]         out_key_reg;
    logic [htlp_pkg::LEN_W-1:0]         out_len_reg;

    // ------------------------------------------------------------------
    // Slot store
    // ------------------------------------------------------------------
    htlp_pkg::store_req_t               store_req;
    logic                               rd_used;
    logic [htlp_pkg::KEY_W-1:0]         rd_key;
    logic [htlp_pkg::LEN_W-1:0]         rd_len;

    htlp_slot_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_used (rd_used),
        .rd_key  (rd_key),
        .rd_len  (rd_len)
    );

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic                               in_beat;
    logic [htlp_pkg::SLOT_IDX_W-1:0]    ptr_inc;
    logic                               key_hit;
    logic                               slot_in_range;

    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == htlp_pkg::ST_IDLE);
    assign ptr_inc       = (ptr_reg == LAST_SLOT) ? '0 : ptr_reg + 1'b1;
    assign key_hit       = (rd_len == len_reg) && (rd_key == key_reg);
    assign slot_in_range = (htlp_pkg::RANGE_W'(slot_reg) <
                            htlp_pkg::RANGE_W'(htlp_pkg::TABLE_SLOTS));

    // Output register loads when empty or being drained this cycle
    assign out_load = (state_reg == htlp_pkg::ST_OUT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        len_next        = len_reg;
        slot_next       = slot_reg;
        asked_next      = asked_reg;
        sum_next        = sum_reg;
        ptr_next        = ptr_reg;
        cnt_next        = cnt_reg;
        res_status_next = res_status_reg;
        res_table_next  = res_table_reg;
        res_slot_next   = res_slot_reg;
        res_key_next    = res_key_reg;
        res_len_next    = res_len_reg;
        store_req       = '0;

        case (state_reg)
            htlp_pkg::ST_IDLE:
            begin
                if (in_beat)
                begin
                    // Capture the canonical request and its byte sum
                    op_next    = s_axis_tuser;
                    key_next   = in_key_masked;
                    len_next   = in_len_clamped;
                    slot_next  = in_slot;
                    asked_next = in_asked;
                    sum_next   = htlp_pkg::key_sum(in_key_masked);

                    // Clear result; error paths leave the zeros in place
                    res_status_next = htlp_pkg::STAT_NOT_FOUND;
                    res_table_next  = '0;
                    res_slot_next   = '0;
                    res_key_next    = '0;
                    res_len_next    = '0;

                    case (s_axis_tuser)
                        htlp_pkg::OP_PUT,
                        htlp_pkg::OP_LOOKUP:
                        begin
                            state_next = htlp_pkg::ST_HASH;
                        end
                        htlp_pkg::OP_READ:
                        begin
                            // Read the addressed slot straight away
                            store_req.rd_en   = 1'b1;
                            store_req.rd_addr = htlp_pkg::SLOT_IDX_W'(in_slot);
                            state_next        = htlp_pkg::ST_CHECK;
                        end
                        default:
                        begin
                            // Unknown operation: not found, all fields zero
                            state_next = htlp_pkg::ST_OUT;
                        end
                    endcase
                end
            end

            htlp_pkg::ST_HASH:
            begin
                // Fold the sum into the home slot and fetch it
                ptr_next          = htlp_pkg::home_slot(sum_reg);
                cnt_next          = '0;
                store_req.rd_en   = 1'b1;
                store_req.rd_addr = htlp_pkg::home_slot(sum_reg);
                state_next        = htlp_pkg::ST_CHECK;
            end

            htlp_pkg::ST_CHECK:
            begin
                if (op_reg == htlp_pkg::OP_READ)
                begin
                    if (asked_reg != table_id_reg)
                    begin
                        res_status_next = htlp_pkg::STAT_WRONG_TABLE;
                    end
                    else if (slot_in_range)
                    begin
                        res_status_next = htlp_pkg::STAT_OK;
                        res_table_next  = table_id_reg;
                        res_slot_next   = slot_reg;
                        if (rd_used)
                        begin
                            res_key_next = rd_key;
                            res_len_next = rd_len;
                        end
                    end
                    state_next = htlp_pkg::ST_OUT;
                end
                else
                begin
                    // Fetch the next slot ahead; dropped if the walk stops here
                    store_req.rd_en   = 1'b1;
                    store_req.rd_addr = ptr_inc;

                    if (!rd_used)
                    begin
                        // Empty slot ends the walk; put claims it
                        if (op_reg == htlp_pkg::OP_PUT)
                        begin
                            store_req.wr_en   = 1'b1;
                            store_req.wr_addr = ptr_reg;
                            store_req.wr_key  = key_reg;
                            store_req.wr_len  = len_reg;
                            res_status_next   = htlp_pkg::STAT_OK;
                            res_table_next    = table_id_reg;
                            res_slot_next     = htlp_pkg::SLOT_NUM_W'(ptr_reg);
                        end
                        state_next = htlp_pkg::ST_OUT;
                    end
                    else if (key_hit)
                    begin
                        res_status_next = htlp_pkg::STAT_OK;
                        res_table_next  = table_id_reg;
                        res_slot_next   = htlp_pkg::SLOT_NUM_W'(ptr_reg);
                        state_next      = htlp_pkg::ST_OUT;
                    end
                    else if (cnt_reg == LAST_SLOT)
                    begin
                        // Full lap without a match or a free slot
                        if (op_reg == htlp_pkg::OP_PUT)
                        begin
                            res_status_next = htlp_pkg::STAT_FULL;
                        end
                        state_next = htlp_pkg::ST_OUT;
                    end
                    else
                    begin
                        ptr_next = ptr_inc;
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end

            htlp_pkg::ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = htlp_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = htlp_pkg::ST_IDLE;
            end
        endcase
    end

    // Output valid: set on load, drop once the beat is taken
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= htlp_pkg::ST_IDLE;
            table_id_reg  <= htlp_pkg::TABLE_ID_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                table_id_reg <= cfg_data;
            end
        end
    end

    // Payload, no reset needed
    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        len_reg        <= len_next;
        slot_reg       <= slot_next;
        asked_reg      <= asked_next;
        sum_reg        <= sum_next;
        ptr_reg        <= ptr_next;
        cnt_reg        <= cnt_next;
        res_status_reg <= res_status_next;
        res_table_reg  <= res_table_next;
        res_slot_reg   <= res_slot_next;
        res_key_reg    <= res_key_next;
        res_len_reg    <= res_len_next;
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_table_reg  <= res_table_reg;
            out_slot_reg   <= res_slot_reg;
            out_key_reg    <= res_key_reg;
            out_len_reg    <= res_len_reg;
        end
    end

    // ------------------------------------------------------------------
    // Ports
    // ------------------------------------------------------------------
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = htlp_pkg::OUT_DATA_W'({out_len_reg, out_key_reg,
                                                  out_slot_reg, out_table_reg});

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------

    // A slot is claimed only by a put that reached an empty slot
    assert property (@(posedge clk) disable iff (!rst_n)
        store_req.wr_en |-> (state_reg == htlp_pkg::ST_CHECK) &&
                            (op_reg == htlp_pkg::OP_PUT) && !rd_used)
        else $error("store write outside a put on an empty slot");

    // The home-slot fetch is always followed by its check
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == htlp_pkg::ST_HASH) |=> (state_reg == htlp_pkg::ST_CHECK))
        else $error("hash step not followed by slot check");

    // A loaded result shows up on the output and the block returns to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> m_axis_tvalid && (state_reg == htlp_pkg::ST_IDLE))
        else $error("result load did not reach the output");

endmodule

### bench/symbol_table_checker.sv
// Result checker for hash_table_linear_probe_core: tracks the slot store and table_id,
// predicts one reply per request beat and compares every result beat against it.
// Depends on htlp_pkg for field widths, beat layout and operation/status codes.
`timescale 1ns / 100ps

module symbol_table_checker
    import htlp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    input  logic                    s_axis_tready,
    input  logic [IN_DATA_W-1:0]    s_axis_tdata,
    input  logic [OP_W-1:0]         s_axis_tuser,
    input  logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    input  logic [OUT_DATA_W-1:0]   m_axis_tdata,
    input  logic [STATUS_W-1:0]     m_axis_tuser,
    input  logic                    cfg_valid,
    input  logic                    cfg_ready,
    input  logic [TABLE_W-1:0]      cfg_data,
    output int                      pending,
    output int                      failures
);

    localparam int RES_SLOT_LSB = TABLE_W;
    localparam int RES_KEY_LSB  = RES_SLOT_LSB + SLOT_NUM_W;
    localparam int RES_LEN_LSB  = RES_KEY_LSB + KEY_W;

    typedef enum logic [1:0] {
        WALK_MATCH,
        WALK_EMPTY,
        WALK_LAP
    } walk_end_t;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [TABLE_W-1:0]    tbl;
        logic [SLOT_NUM_W-1:0] slot;
        logic [KEY_W-1:0]      key;
        logic [LEN_W-1:0]      len;
    } table_reply_t;

    logic                  slot_taken [TABLE_SLOTS];
    logic [KEY_W-1:0]      slot_keys  [TABLE_SLOTS];
    logic [LEN_W-1:0]      slot_lens  [TABLE_SLOTS];
    logic [TABLE_W-1:0]    id_now;
    table_reply_t          replies_due [$];
    table_reply_t          seen_reply;
    table_reply_t          due_reply;

    // Apply one request to the shadow store and return the reply it must produce.
    function automatic table_reply_t resolve_request(input logic [OP_W-1:0] op,
                                                     input logic [KEY_W-1:0] raw_key,
                                                     input logic [LEN_W-1:0] raw_len,
                                                     input logic [SLOT_NUM_W-1:0] slot,
                                                     input logic [TABLE_W-1:0] asked);
        table_reply_t     r;
        logic [LEN_W-1:0] len;
        logic [KEY_W-1:0] key;
        int               home;
        int               at;
        int               stop;
        int               i;
        walk_end_t        walk;

        r = '0;
        r.status = STAT_NOT_FOUND;
        len = (raw_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : raw_len;
        key = '0;
        home = 0;
        for (i = 0; i < KEY_BYTES; i++)
        begin
            if (i < int'(len))
            begin
                key[8*i +: 8] = raw_key[8*i +: 8];
                home += int'(raw_key[8*i +: 8]);
            end
        end
        home = home % TABLE_SLOTS;

        // Walk from the home slot until a match, a hole, or a full lap
        walk = WALK_LAP;
        stop = 0;
        for (i = 0; i < TABLE_SLOTS && walk == WALK_LAP; i++)
        begin
            at = (home + i) % TABLE_SLOTS;
            if (!slot_taken[at])
            begin
                walk = WALK_EMPTY;
                stop = at;
            end
            else if (slot_lens[at] == len && slot_keys[at] == key)
            begin
                walk = WALK_MATCH;
                stop = at;
            end
        end

        case (op)
            OP_PUT:
            begin
                if (walk == WALK_LAP)
                begin
                    r.status = STAT_FULL;
                end
                else
                begin
                    if (walk == WALK_EMPTY)
                    begin
                        slot_taken[stop] = 1'b1;
                        slot_keys[stop]  = key;
                        slot_lens[stop]  = len;
                    end
                    r.status = STAT_OK;
                    r.slot   = SLOT_NUM_W'(stop);
                end
            end
            OP_LOOKUP:
            begin
                if (walk == WALK_MATCH)
                begin
                    r.status = STAT_OK;
                    r.slot   = SLOT_NUM_W'(stop);
                end
            end
            OP_READ:
            begin
                if (asked != id_now)
                begin
                    r.status = STAT_WRONG_TABLE;
                end
                else if (int'(slot) < TABLE_SLOTS)
                begin
                    r.status = STAT_OK;
                    r.slot   = slot;
                    if (slot_taken[slot])
                    begin
                        r.key = slot_keys[slot];
                        r.len = slot_lens[slot];
                    end
                end
            end
            default:
            begin
                r.status = STAT_NOT_FOUND;
            end
        endcase

        if (r.status == STAT_OK)
            r.tbl = id_now;
        return r;
    endfunction

    task automatic compare_reply(input table_reply_t want, input table_reply_t got);
        if (got.status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            failures++;
        end
        if (got.tbl !== want.tbl)
        begin
            $error("result_table: expected %0d, got %0d", want.tbl, got.tbl);
            failures++;
        end
        if (got.slot !== want.slot)
        begin
            $error("result_slot: expected %0d, got %0d", want.slot, got.slot);
            failures++;
        end
        if (got.key !== want.key)
        begin
            $error("result_key: expected %h, got %h", want.key, got.key);
            failures++;
        end
        if (got.len !== want.len)
        begin
            $error("result_length: expected %0d, got %0d", want.len, got.len);
            failures++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TABLE_SLOTS; i++)
                slot_taken[i] = 1'b0;
            id_now = TABLE_ID_RESET;
            replies_due.delete();
            failures = 0;
            pending <= 0;
        end
        else
        begin
            // Retire the result beat first; a request in the same cycle is newer
            if (m_axis_tvalid && m_axis_tready)
            begin
                seen_reply.status = m_axis_tuser;
                seen_reply.tbl    = m_axis_tdata[0 +: TABLE_W];
                seen_reply.slot   = m_axis_tdata[RES_SLOT_LSB +: SLOT_NUM_W];
                seen_reply.key    = m_axis_tdata[RES_KEY_LSB +: KEY_W];
                seen_reply.len    = m_axis_tdata[RES_LEN_LSB +: LEN_W];
                if (replies_due.size() == 0)
                begin
                    $error("result beat with no request outstanding (status %0d)",
                           seen_reply.status);
                    failures++;
                end
                else
                begin
                    due_reply = replies_due.pop_front();
                    compare_reply(due_reply, seen_reply);
                end
            end
            if (cfg_valid && cfg_ready)
                id_now = cfg_data;
            if (s_axis_tvalid && s_axis_tready)
                replies_due.push_back(resolve_request(s_axis_tuser,
                                                      s_axis_tdata[0 +: KEY_W],
                                                      s_axis_tdata[IN_LEN_LSB +: LEN_W],
                                                      s_axis_tdata[IN_SLOT_LSB +: SLOT_NUM_W],
                                                      s_axis_tdata[IN_ASKED_LSB +: TABLE_W]));
            pending <= replies_due.size();
        end
    end

endmodule

### bench/tb.sv
// Top of the bench for hash_table_linear_probe_core: clock, reset, request and
// table_id stimulus, result back-pressure and the verdict. Depends on htlp_pkg,
// the core and symbol_table_checker, which predicts and compares every result beat.
`timescale 1ns / 100ps

module tb;
    import htlp_pkg::*;

    // Opcode left undefined by the package; the core must answer it with not found
    localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

    // Worst correct run: ~1800 beats, each with a full probe walk plus the largest
    // request gap and result stall; allow several times that.
    localparam int CYCLE_LIMIT  = 1_500_000;
    localparam int PHASES       = 7;
    localparam int PER_PHASE    = 250;
    localparam int DRAIN_CYCLES = 140;

    logic                    clk;
    logic                    rst_n;
    logic                    s_axis_tvalid;
    logic                    s_axis_tready;
    logic [IN_DATA_W-1:0]    s_axis_tdata;
    logic [OP_W-1:0]         s_axis_tuser;
    logic                    m_axis_tvalid;
    logic                    m_axis_tready;
    logic [OUT_DATA_W-1:0]   m_axis_tdata;
    logic [STATUS_W-1:0]     m_axis_tuser;
    logic                    cfg_valid;
    logic                    cfg_ready;
    logic [TABLE_W-1:0]      cfg_data;

    int                      pending;
    int                      failures;
    int                      cycles;

    // Shared between the request and result sides: no idling while set
    logic                    calm;
    logic [TABLE_W-1:0]      cur_id;

    // Keys already put (masked to their clamped length), reused for hits
    logic [KEY_W-1:0]        known_keys [$];
    logic [LEN_W-1:0]        known_lens [$];

    int                      n_put;
    int                      n_lookup;
    int                      n_read;
    int                      n_other;

    hash_table_linear_probe_core dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    symbol_table_checker table_check
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .pending       (pending),
        .failures      (failures)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Hard stop: end the run if it hangs anywhere
    initial
    begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // Result side: hold tready low for a random stall before each beat, none while calm
    initial
    begin
        int stall;

        m_axis_tready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            stall = calm ? 0 : $urandom_range(0, 5);
            if (stall != 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    function automatic logic [KEY_W-1:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // Ones over the first n bytes (n clamped to the key size)
    function automatic logic [KEY_W-1:0] byte_mask(input logic [LEN_W-1:0] n);
        if (n >= LEN_W'(MAX_KEY_BYTES))
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    // Drive one request beat after a random gap and hold it until accepted.
    // Keep tvalid high across back-to-back beats instead of dropping it.
    task automatic issue(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key,
                         input logic [LEN_W-1:0] len, input logic [SLOT_NUM_W-1:0] slot,
                         input logic [TABLE_W-1:0] asked);
        int gap;

        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap != 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= IN_DATA_W'({asked, slot, len, key});
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Put a key and remember its masked form so later lookups can hit it
    task automatic put_key(input logic [KEY_W-1:0] key, input logic [LEN_W-1:0] len);
        logic [LEN_W-1:0] eff;

        eff = (len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : len;
        known_keys.push_back(key & byte_mask(eff));
        known_lens.push_back(eff);
        issue(OP_PUT, key, len, SLOT_NUM_W'($urandom), TABLE_W'($urandom));
        n_put++;
    endtask

    // Mostly 1..8 bytes; now and then the empty key or an over-long length
    task automatic fresh_key(output logic [KEY_W-1:0] key, output logic [LEN_W-1:0] len);
        int pick;

        pick = $urandom_range(0, 19);
        key = random_word();
        if (pick == 0)
            len = '0;
        else if (pick < 3)
            len = LEN_W'($urandom_range(MAX_KEY_BYTES + 1, 15));
        else
            len = LEN_W'($urandom_range(1, MAX_KEY_BYTES));
    endtask

    // A stored key, often with junk in the unused bytes or an over-long length
    task automatic known_key(output logic [KEY_W-1:0] key, output logic [LEN_W-1:0] len);
        int idx;

        if (known_keys.size() == 0)
        begin
            fresh_key(key, len);
            return;
        end
        idx = $urandom_range(0, known_keys.size() - 1);
        key = known_keys[idx];
        len = known_lens[idx];
        if ($urandom_range(0, 1) == 1)
            key = key | (random_word() & ~byte_mask(len));
        if (len == LEN_W'(MAX_KEY_BYTES) && $urandom_range(0, 1) == 1)
            len = LEN_W'($urandom_range(MAX_KEY_BYTES, 15));
    endtask

    // Drop tvalid and wait until every outstanding result beat has come back
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    // Write table_id only with the core idle
    task automatic write_table_id(input logic [TABLE_W-1:0] id);
        settle();
        cfg_valid <= 1'b1;
        cfg_data  <= id;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_id = id;
    endtask

    initial
    begin
        logic [KEY_W-1:0] key;
        logic [LEN_W-1:0] len;
        logic [TABLE_W-1:0] id;
        int pick;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = OP_PUT;
        cfg_valid     = 1'b0;
        cfg_data      = TABLE_ID_RESET;
        calm          = 1'b0;
        cur_id        = TABLE_ID_RESET;
        n_put         = 0;
        n_lookup      = 0;
        n_read        = 0;
        n_other       = 0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, run with table_id at its reset value.
        // Read empty slots at both ends, then with wrong table ids.
        issue(OP_READ, '0, '0, SLOT_NUM_W'(0), cur_id);
        issue(OP_READ, '1, '1, SLOT_NUM_W'(TABLE_SLOTS - 1), cur_id);
        issue(OP_READ, '0, '0, SLOT_NUM_W'(5), TABLE_W'(0));
        issue(OP_READ, '1, '1, SLOT_NUM_W'(5), TABLE_W'(15));
        // Empty key: miss on an empty table, store at slot 0, hit despite stray bytes
        issue(OP_LOOKUP, '0, '0, '0, '0);
        put_key('0, '0);
        issue(OP_LOOKUP, '1, '0, '1, '1);
        // Widest key, all ones; the long length must clamp to the same key
        put_key('1, LEN_W'(MAX_KEY_BYTES));
        put_key('1, LEN_W'(15));
        issue(OP_LOOKUP, '1, LEN_W'(12), '0, '0);
        // One-byte key with junk above it, then a two-byte key on the same home slot
        put_key(64'hDEAD_BEEF_1234_5641, LEN_W'(1));
        put_key(64'h0000_0000_0000_4001, LEN_W'(2));
        issue(OP_LOOKUP, 64'h0000_0000_0000_4001, LEN_W'(2), '0, '0);
        issue(OP_READ, '0, '0, SLOT_NUM_W'(66), cur_id);
        issue(OP_READ, '0, '0, SLOT_NUM_W'(65), cur_id);
        // Miss that walks past the collision chain to the hole after it
        issue(OP_LOOKUP, 64'h0000_0000_0000_0042, LEN_W'(1), '0, '0);
        // Last slot, then a key homed there that wraps past slot 0
        put_key(64'h0000_0000_0000_007F, LEN_W'(1));
        put_key(64'h0000_0000_0000_00FF, LEN_W'(2));
        issue(OP_READ, '0, '0, SLOT_NUM_W'(1), cur_id);
        issue(OP_READ, '1, '1, SLOT_NUM_W'(TABLE_SLOTS - 1), cur_id);
        // Undefined opcode with every field set
        issue(OP_UNDEFINED, '1, '1, '1, '1);
        issue(OP_UNDEFINED, '0, '0, '0, '0);
        n_lookup += 5;
        n_read   += 8;
        n_other  += 2;

        // Random part: one table_id per phase, ids 15 and 1 among them.
        // About half of the puts bring a new key, so the table fills part way
        // through and the later phases run on a full table.
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
                id = TABLE_W'(15);
            else if (phase == 3)
                id = TABLE_W'(1);
            else
                id = TABLE_W'($urandom_range(1, 15));
            write_table_id(id);

            for (int item = 0; item < PER_PHASE; item++)
            begin
                // Run the first beats of odd phases with no idling on either side
                calm = (phase % 2 == 1) && (item < 30);
                pick = $urandom_range(0, 99);
                if (pick < 30)
                begin
                    if ($urandom_range(0, 1) == 1)
                        fresh_key(key, len);
                    else
                        known_key(key, len);
                    put_key(key, len);
                end
                else if (pick < 65)
                begin
                    if ($urandom_range(0, 4) < 3)
                        known_key(key, len);
                    else
                        fresh_key(key, len);
                    issue(OP_LOOKUP, key, len, SLOT_NUM_W'($urandom), TABLE_W'($urandom));
                    n_lookup++;
                end
                else if (pick < 92)
                begin
                    id = ($urandom_range(0, 4) != 0) ? cur_id : TABLE_W'($urandom_range(0, 15));
                    issue(OP_READ, random_word(), LEN_W'($urandom),
                          SLOT_NUM_W'($urandom_range(0, TABLE_SLOTS - 1)), id);
                    n_read++;
                end
                else
                begin
                    // Noise: any opcode, any field values
                    issue(OP_W'($urandom), random_word(), LEN_W'($urandom),
                          SLOT_NUM_W'($urandom), TABLE_W'($urandom));
                    n_other++;
                end
            end
        end
        calm = 1'b0;

        // Drain, then give stray beats time to show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d puts, %0d lookups, %0d slot reads and %0d other beats",
                 n_put, n_lookup, n_read, n_other);
        $display("over %0d table_id settings, filling the table and probing it full",
                 PHASES + 1);
        if (failures == 0 && pending == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

### sim.f
rtl/htlp_pkg.sv
rtl/htlp_slot_store.sv
rtl/hash_table_linear_probe_core.sv
bench/symbol_table_checker.sv
bench/tb.sv
